FILE: sv/tbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbu_pkg;

  localparam int InDataW  = 104;
  localparam int OutDataW = 72;
  localparam int ItemW    = 98;
  localparam int ResW     = 68;

  typedef enum logic [2:0] {
    ACT_BX      = 3'd0,
    ACT_BCOND   = 3'd1,
    ACT_B       = 3'd2,
    ACT_BL_PRE  = 3'd3,
    ACT_BL_SUF  = 3'd4
  } action_t;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] COND_NV = 4'd15;

  localparam logic [1:0] CYC_SHORT = 2'd1;
  localparam logic [1:0] CYC_LONG  = 2'd3;

  localparam logic [31:0] PC_MASK = 32'hFFFF_FFFE;

  // first member sits in the high bits
  typedef struct packed {
    logic [3:0]         flags_nzcv;
    logic [3:0]         cond_code;
    logic signed [22:0] offset;
    logic [31:0]        reg_value;
    logic [31:0]        current_pc;
    action_t            action;
  } item_t;

  typedef struct packed {
    logic [1:0]  cycle_count;
    logic        thumb_state;
    logic [31:0] link_value;
    logic        branch_taken;
    logic [31:0] next_pc;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/tbu_cond.sv
`timescale 1ns / 1ps
`default_nettype none

module tbu_cond
  import tbu_pkg::*;
(
  input  wire logic [3:0] cond_code,
  input  wire logic [3:0] flags_nzcv,
  output logic            holds
);

  logic n, z, c, v;

  assign n = flags_nzcv[3];
  assign z = flags_nzcv[2];
  assign c = flags_nzcv[1];
  assign v = flags_nzcv[0];

  always_comb begin
    case (cond_code)
      COND_EQ: holds = z;
      COND_NE: holds = !z;
      COND_CS: holds = c;
      COND_CC: holds = !c;
      COND_MI: holds = n;
      COND_PL: holds = !n;
      COND_VS: holds = v;
      COND_VC: holds = !v;
      COND_HI: holds = c && !z;
      COND_LS: holds = !c || z;
      COND_GE: holds = (n == v);
      COND_LT: holds = (n != v);
      COND_GT: holds = !z && (n == v);
      COND_LE: holds = z || (n != v);
      COND_AL: holds = 1'b1;
      COND_NV: holds = 1'b0;
      default: holds = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tbu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module tbu_exec
  import tbu_pkg::*;
(
  input  wire item_t        item,
  input  wire logic [31:0]  link_cur,
  input  wire logic         thumb_cur,
  output result_t           res,
  output logic [31:0]       link_nxt,
  output logic              thumb_nxt
);

  logic        cond_ok;
  logic [31:0] off_ext;
  logic [31:0] rel_target;
  logic [31:0] bx_target;
  logic [31:0] suf_target;

  tbu_cond u_cond (
    .cond_code  (item.cond_code),
    .flags_nzcv (item.flags_nzcv),
    .holds      (cond_ok)
  );

  assign off_ext    = {{9{item.offset[22]}}, item.offset};
  assign rel_target = item.current_pc + 32'd2 + off_ext;
  // ARM-state target carries the extra word of prefetch
  assign bx_target  = (item.reg_value + (item.reg_value[0] ? 32'd2 : 32'd6)) & PC_MASK;
  assign suf_target = (link_cur + off_ext + 32'd2) & PC_MASK;

  always_comb begin
    link_nxt          = link_cur;
    thumb_nxt         = thumb_cur;
    res.next_pc       = item.current_pc;
    res.branch_taken  = 1'b0;
    res.cycle_count   = CYC_SHORT;
    case (item.action)
      ACT_BX: begin
        thumb_nxt        = item.reg_value[0];
        res.next_pc      = bx_target;
        res.branch_taken = 1'b1;
        res.cycle_count  = CYC_LONG;
      end
      ACT_BCOND: begin
        if (cond_ok) begin
          res.next_pc      = rel_target;
          res.branch_taken = 1'b1;
        end
        res.cycle_count = CYC_LONG;
      end
      ACT_B: begin
        res.next_pc      = rel_target;
        res.branch_taken = 1'b1;
        res.cycle_count  = CYC_LONG;
      end
      ACT_BL_PRE: begin
        link_nxt = item.current_pc + off_ext;
      end
      ACT_BL_SUF: begin
        link_nxt         = (item.current_pc - 32'd2) | 32'd1;
        res.next_pc      = suf_target;
        res.branch_taken = 1'b1;
        res.cycle_count  = CYC_LONG;
      end
      default: ;
    endcase
    res.link_value  = link_nxt;
    res.thumb_state = thumb_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/thumb_branch_unit.sv
// An accepted input item passes the input register, then the result register, to reach out_tvalid.
// Throughput: 1 item per cycle unless out_tready stalls it; lr and the Thumb bit update on the
// input-to-result register step, so each item sees the state left by the one before it.
// Reset (rst_n low, synchronous): both stages empty, lr = 0, Thumb state = 1.
`timescale 1ns / 1ps
`default_nettype none

module thumb_branch_unit
  import tbu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // action[2:0], current_pc[34:3], reg_value[66:35], offset[89:67],
  // cond_code[93:90], flags_nzcv[97:94], zero pad above
  input  wire logic [InDataW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // next_pc[31:0], branch_taken[32], link_value[64:33], thumb_state[65],
  // cycle_count[67:66], zero pad above
  output logic [OutDataW-1:0]      out_tdata
);

  item_t       item_r;
  logic        item_vld_r;
  result_t     res_r;
  result_t     res_nxt;
  logic        res_vld_r;
  logic [31:0] link_r;
  logic [31:0] link_nxt;
  logic        thumb_r;
  logic        thumb_nxt;
  logic        adv;

  // the result register can take the pending item
  assign adv       = !res_vld_r || out_tready;
  assign in_tready = !item_vld_r || adv;

  tbu_exec u_exec (
    .item      (item_r),
    .link_cur  (link_r),
    .thumb_cur (thumb_r),
    .res       (res_nxt),
    .link_nxt  (link_nxt),
    .thumb_nxt (thumb_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      link_r     <= 32'd0;
      thumb_r    <= 1'b1;
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (adv) begin
        res_vld_r <= item_vld_r;
      end
      if (item_vld_r && adv) begin
        link_r  <= link_nxt;
        thumb_r <= thumb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[ItemW-1:0]);
    end
    if (item_vld_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OutDataW-ResW){1'b0}}, res_r};

  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (thumb_r && (link_r == 32'd0)))
    else $error("state not at reset value after reset");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(item_vld_r && adv) |=> ($stable(link_r) && $stable(thumb_r)))
    else $error("state changed without an item moving to the result register");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> item_vld_r)
    else $error("accepted item not held in the input register");

  a_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> ((res_r.cycle_count == CYC_SHORT && !res_r.branch_taken)
                   || res_r.cycle_count == CYC_LONG))
    else $error("bad cycle count or taken short op");

endmodule

`default_nettype wire
